FILE: design/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types and constants of the header table size ring
// ----------------------------------------------------------------------------
package hts_pkg;

  localparam logic [17:0] ENTRY_OVERHEAD = 18'd32;
  localparam logic [15:0] STATIC_COUNT   = 16'd61;
  localparam logic [15:0] FIRST_DYNAMIC  = 16'd62;
  localparam logic [15:0] RESET_LIMIT    = 16'd4096;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_FLUSHED = 3'd1;
  localparam logic [2:0] ST_STATIC  = 3'd2;
  localparam logic [2:0] ST_DYNAMIC = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] position;
    logic [11:0] evicted_count;
    logic [11:0] entries_in_use;
    logic [15:0] bytes_in_use;
  } hts_result_t;

endpackage

FILE: design/hts_in_if.sv
// ----------------------------------------------------------------------------
// hts_in_if
// Input channel: insert or lookup word with valid/ready handshake
// ----------------------------------------------------------------------------
interface hts_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] name_length;
  logic [15:0] value_length;
  logic [15:0] entry_index;

  modport source (output valid, output func, output name_length, output value_length,
                  output entry_index, input ready);
  modport sink   (input valid, input func, input name_length, input value_length,
                  input entry_index, output ready);
endinterface

FILE: design/hts_out_if.sv
// ----------------------------------------------------------------------------
// hts_out_if
// Result channel: one result word per input word, valid/ready handshake
// ----------------------------------------------------------------------------
interface hts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [10:0] position;
  logic [11:0] evicted_count;
  logic [11:0] entries_in_use;
  logic [15:0] bytes_in_use;

  modport source (output valid, output status, output position, output evicted_count,
                  output entries_in_use, output bytes_in_use, input ready);
  modport sink   (input valid, input status, input position, input evicted_count,
                  input entries_in_use, input bytes_in_use, output ready);
endinterface

FILE: design/hts_ram.sv
// ----------------------------------------------------------------------------
// hts_ram
// Generic single write, single read RAM with registered read data
// ----------------------------------------------------------------------------
module hts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

FILE: design/hts_ring_add.sv
// ----------------------------------------------------------------------------
// hts_ring_add
// Shared ring address unit: base plus offset, wrapped once at the slot count
// ----------------------------------------------------------------------------
module hts_ring_add #(
  parameter int SLOTS = 2048
) (
  input  logic [$clog2(SLOTS)-1:0] base,
  input  logic [$clog2(SLOTS+1)-1:0] offset,
  output logic [$clog2(SLOTS)-1:0] sum
);

  localparam int HW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SW = CW + 1;

  logic [SW-1:0] raw;

  always_comb begin
    raw = SW'(base) + SW'(offset);
    if (raw >= SW'(SLOTS)) begin
      raw = raw - SW'(SLOTS);
    end
    sum = raw[HW-1:0];
  end

endmodule

FILE: design/hts_ctrl.sv
// ----------------------------------------------------------------------------
// hts_ctrl
// Sequencer: insert with eviction loop, flush, and index lookup
// ----------------------------------------------------------------------------
module hts_ctrl #(
  parameter int SLOTS = 2048
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       func,
  input  logic [15:0]                name_length,
  input  logic [15:0]                value_length,
  input  logic [15:0]                entry_index,
  input  logic [15:0]                byte_limit,
  input  logic                       out_free,
  output logic                       idle,
  output logic                       res_valid,
  output hts_pkg::hts_result_t       res,
  output logic                       ram_we,
  output logic [$clog2(SLOTS)-1:0]   ram_waddr,
  output logic [15:0]                ram_wdata,
  output logic                       ram_re,
  output logic [$clog2(SLOTS)-1:0]   ram_raddr,
  input  logic [15:0]                ram_rdata
);

  localparam int HW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic          func_r;
  logic [17:0]   cost_r;
  logic [15:0]   idx_r;
  logic [HW-1:0] head_r, head_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [15:0]   bytes_r, bytes_nxt;
  logic [CW-1:0] evicted_r, evicted_nxt;

  logic          too_big;
  logic          over;
  logic          need_evict;
  logic [15:0]   idx_off;
  logic          dyn_hit;
  logic [HW-1:0] head_m1;
  logic [CW-1:0] add_offset;
  logic [HW-1:0] add_sum;

  hts_ring_add #(.SLOTS(SLOTS)) u_add (
    .base   (head_r),
    .offset (add_offset),
    .sum    (add_sum)
  );

  always_comb begin
    too_big    = cost_r > {2'b00, byte_limit};
    over       = ({2'b00, bytes_r} + cost_r) > {2'b00, byte_limit};
    need_evict = (over && (total_r != '0)) || (total_r >= CW'(SLOTS));
    idx_off    = idx_r - hts_pkg::FIRST_DYNAMIC;
    dyn_hit    = (idx_r >= hts_pkg::FIRST_DYNAMIC) && (idx_off < 16'(total_r));
    head_m1    = (head_r == '0) ? HW'(SLOTS - 1) : head_r - HW'(1);
    add_offset = (func_r == hts_pkg::FUNC_LOOKUP) ? idx_off[CW-1:0] : total_r - CW'(1);
  end

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    total_nxt   = total_r;
    bytes_nxt   = bytes_r;
    evicted_nxt = evicted_r;
    res_valid   = 1'b0;
    res         = '0;
    ram_we      = 1'b0;
    ram_waddr   = head_m1;
    ram_wdata   = cost_r[15:0];
    ram_re      = 1'b0;
    ram_raddr   = add_sum;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          evicted_nxt = '0;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (func_r == hts_pkg::FUNC_LOOKUP) begin
          if (out_free) begin
            res_valid          = 1'b1;
            res.entries_in_use = 12'(total_r);
            res.bytes_in_use   = bytes_r;
            if ((idx_r != '0) && (idx_r <= hts_pkg::STATIC_COUNT)) begin
              res.status   = hts_pkg::ST_STATIC;
              res.position = 11'(idx_r - 16'd1);
            end else if (dyn_hit) begin
              res.status   = hts_pkg::ST_DYNAMIC;
              res.position = 11'(add_sum);
            end else begin
              res.status = hts_pkg::ST_INVALID;
            end
            state_nxt = S_IDLE;
          end
        end else if (too_big) begin
          if (out_free) begin
            res_valid         = 1'b1;
            res.status        = hts_pkg::ST_FLUSHED;
            res.evicted_count = 12'(evicted_r + total_r);
            total_nxt         = '0;
            bytes_nxt         = '0;
            state_nxt         = S_IDLE;
          end
        end else if (need_evict) begin
          ram_re    = 1'b1;
          total_nxt = total_r - CW'(1);
          state_nxt = S_WAIT;
        end else if (out_free) begin
          ram_we             = 1'b1;
          head_nxt           = head_m1;
          bytes_nxt          = bytes_r + cost_r[15:0];
          total_nxt          = total_r + CW'(1);
          res_valid          = 1'b1;
          res.status         = hts_pkg::ST_STORED;
          res.position       = 11'(head_m1);
          res.evicted_count  = 12'(evicted_r);
          res.entries_in_use = 12'(total_nxt);
          res.bytes_in_use   = bytes_nxt;
          state_nxt          = S_IDLE;
        end
      end
      S_WAIT: begin
        bytes_nxt   = (ram_rdata > bytes_r) ? 16'd0 : bytes_r - ram_rdata;
        evicted_nxt = evicted_r + CW'(1);
        state_nxt   = S_EVAL;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign idle = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      total_r   <= '0;
      bytes_r   <= '0;
      evicted_r <= '0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      total_r   <= total_nxt;
      bytes_r   <= bytes_nxt;
      evicted_r <= evicted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && idle) begin
      func_r <= func;
      cost_r <= hts_pkg::ENTRY_OVERHEAD + {2'b00, name_length} + {2'b00, value_length};
      idx_r  <= entry_index;
    end
  end

endmodule

FILE: design/header_table_size_ring.sv
// ----------------------------------------------------------------------------
// header_table_size_ring
// Size bookkeeping of a dynamic header table kept as a ring of slots
//
//   channel   dir  handshake          payload
//   in_word   in   valid/ready        func, name_length, value_length, entry_index
//   out_word  out  valid/ready        status, position, evicted_count,
//                                     entries_in_use, bytes_in_use
//   cfg       in   cfg_we             cfg_wdata (size limit, capped)
//
// a lookup, flush or insert without eviction is taken in idle and finished in eval
// each evicted entry adds one slot cost read from the ring ram in eval
// and one subtract of that cost from the byte count in wait, then eval again
// reset is synchronous; the table starts empty, size limit 4096
// a new word is taken while a result waits; completion stalls on a full output
// ----------------------------------------------------------------------------
module header_table_size_ring #(
  parameter int SLOTS           = 2048,
  parameter int MAX_TABLE_BYTES = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  hts_in_if.sink      in_word,
  hts_out_if.source   out_word
);

  localparam int HW = $clog2(SLOTS);

  logic [15:0]          limit_r;
  logic                 out_valid_r;
  hts_pkg::hts_result_t out_r;
  logic                 out_free;
  logic                 idle;
  logic                 res_valid;
  hts_pkg::hts_result_t res;
  logic                 ram_we;
  logic [HW-1:0]        ram_waddr;
  logic [15:0]          ram_wdata;
  logic                 ram_re;
  logic [HW-1:0]        ram_raddr;
  logic [15:0]          ram_rdata;

  assign out_free      = !out_valid_r || out_word.ready;
  assign in_word.ready = idle;

  hts_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_word.valid),
    .func         (in_word.func),
    .name_length  (in_word.name_length),
    .value_length (in_word.value_length),
    .entry_index  (in_word.entry_index),
    .byte_limit   (limit_r),
    .out_free     (out_free),
    .idle         (idle),
    .res_valid    (res_valid),
    .res          (res),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  hts_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_cost_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= hts_pkg::RESET_LIMIT;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= (cfg_wdata > 16'(MAX_TABLE_BYTES)) ? 16'(MAX_TABLE_BYTES) : cfg_wdata;
      end
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_word.valid          = out_valid_r;
  assign out_word.status         = out_r.status;
  assign out_word.position       = out_r.position;
  assign out_word.evicted_count  = out_r.evicted_count;
  assign out_word.entries_in_use = out_r.entries_in_use;
  assign out_word.bytes_in_use   = out_r.bytes_in_use;

endmodule

FILE: design/hts_checker.sv
// ----------------------------------------------------------------------------
// hts_checker
// Port-level checks on the result channel of the header table size ring
// ----------------------------------------------------------------------------
module hts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [10:0] position,
  input logic [11:0] evicted_count,
  input logic [11:0] entries_in_use,
  input logic [15:0] bytes_in_use
);

  // no result word straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a flush leaves the table empty
  a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (status == hts_pkg::ST_FLUSHED)) |->
      (entries_in_use == '0) && (bytes_in_use == '0) && (position == '0))
    else $error("flush did not empty the table");

  // lookups never evict
  a_lookup_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((status == hts_pkg::ST_STATIC) || (status == hts_pkg::ST_DYNAMIC) ||
                   (status == hts_pkg::ST_INVALID))) |-> (evicted_count == '0))
    else $error("lookup reported evictions");

  // invalid index gives position zero
  a_invalid_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (status == hts_pkg::ST_INVALID)) |-> (position == '0))
    else $error("invalid index with non-zero position");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(position) &&
                                   $stable(bytes_in_use)))
    else $error("stalled result word changed");

endmodule

bind header_table_size_ring hts_checker u_hts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_word.valid),
  .out_ready      (out_word.ready),
  .status         (out_word.status),
  .position       (out_word.position),
  .evicted_count  (out_word.evicted_count),
  .entries_in_use (out_word.entries_in_use),
  .bytes_in_use   (out_word.bytes_in_use)
);
